### rtl/core/entry_id_free_list_allocator_assert.svh
`ifndef ENTRY_ID_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define ENTRY_ID_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define EIDA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("eida: invariant violated");

`define EIDA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eida: implication violated");

`define EIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eida: next-cycle check violated");

`else

`define EIDA_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define EIDA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define EIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/eida_pkg.sv
package eida_pkg;

    localparam int CHUNK_ENTRIES = 64;
    localparam int CHUNK_COUNT   = 16;
    localparam int CAPACITY      = CHUNK_ENTRIES * CHUNK_COUNT;

    localparam int ID_W   = 10;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 2;
    localparam int BUMP_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (BUMP_W > CNT_W) ? BUMP_W : CNT_W;

    // link word: end-of-list flag above the next id
    localparam int LINK_W     = ID_W + 1;
    localparam int LINK_DEPTH = 1 << ID_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  live;
    } result_t;

endpackage

### rtl/core/eida_ram.sv
module eida_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/entry_id_free_list_allocator.sv
// Entry id allocator: LIFO free list of released ids in front of a bump counter.
// Input channel (in_valid/in_ready) carries one word per request: action selects
// allocate or free, free_id names the id to release. Every request gives exactly
// one result word on the output channel (out_valid/out_ready): status, granted_id
// and the live count after the request.
// Throughput: one request per cycle unless in_ready drops, except an allocate
// that pops the free list: the link of the popped head is read from the link
// RAM (registered read) before the next request can be taken. The result is
// registered in the output register; a pop's result follows the link read.
// When the receiver stalls, one more request is finished into a skid register;
// in_ready then drops until the output drains.
// Reset empties the list, clears the bump counter, live count and the limit
// register. Link RAM contents are never cleared: an entry is only read after a
// free has written it. The user writes entry_limit through entry_limit_we only
// while idle; the block itself does not enforce it.
module entry_id_free_list_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          entry_limit_we,
    input  logic [eida_pkg::CNT_W-1:0]    entry_limit,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [eida_pkg::ID_W-1:0]     free_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [eida_pkg::STAT_W-1:0]   status,
    output logic [eida_pkg::ID_W-1:0]     granted_id,
    output logic [eida_pkg::CNT_W-1:0]    live_count
);

`include "entry_id_free_list_allocator_assert.svh"

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic                            state_reg, state_next;
    logic [eida_pkg::CNT_W-1:0]      limit_reg;
    logic [eida_pkg::ID_W-1:0]       head_reg, head_next;
    logic                            nonempty_reg, nonempty_next;
    logic [eida_pkg::BUMP_W-1:0]     bump_reg, bump_next;
    logic [eida_pkg::BUMP_W-1:0]     reached_reg, reached_next;
    logic [eida_pkg::CNT_W-1:0]      live_reg, live_next;

    logic                            out_valid_reg;
    eida_pkg::result_t               out_reg;
    logic                            skid_valid_reg;
    eida_pkg::result_t               skid_reg;

    eida_pkg::result_t               res;
    logic                            res_valid;

    logic                            in_fire;
    logic                            out_free;
    logic [eida_pkg::CMP_W-1:0]      limit_eff;
    logic [eida_pkg::CNT_W-1:0]      live_inc;
    logic [eida_pkg::CNT_W-1:0]      live_dec;

    logic                            ram_we;
    logic                            ram_re;
    logic [eida_pkg::LINK_W-1:0]     ram_wdata;
    logic [eida_pkg::LINK_W-1:0]     ram_rdata;

    eida_ram #(
        .WIDTH (eida_pkg::LINK_W),
        .DEPTH (eida_pkg::LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_id),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE) && !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign limit_eff = (limit_reg == '0) ? eida_pkg::CMP_W'(eida_pkg::CAPACITY)
                                         : eida_pkg::CMP_W'(limit_reg);
    assign live_inc  = (live_reg == eida_pkg::CNT_MAX) ? live_reg
                                                       : live_reg + 1'b1;
    assign live_dec  = (live_reg == '0) ? live_reg : live_reg - 1'b1;

    // bit above the link marks the last entry of the list
    assign ram_wdata = {!nonempty_reg, head_reg};

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        bump_next     = bump_reg;
        reached_next  = reached_reg;
        live_next     = live_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        res_valid     = 1'b0;
        res.status    = eida_pkg::ST_OK;
        res.id        = '0;
        res.live      = live_reg;

        if (state_reg == S_POP)
        begin
            head_next     = ram_rdata[eida_pkg::ID_W-1:0];
            nonempty_next = !ram_rdata[eida_pkg::ID_W];
            live_next     = live_inc;
            state_next    = S_IDLE;
            res_valid     = 1'b1;
            res.id        = head_reg;
            res.live      = live_inc;
        end
        else if (in_fire)
        begin
            res_valid = 1'b1;
            if (action == eida_pkg::ACT_ALLOC)
            begin
                priority if (eida_pkg::CMP_W'(live_reg) >= limit_eff)
                begin
                    res.status = eida_pkg::ST_NOMEM;
                end
                else if (nonempty_reg)
                begin
                    // result comes next cycle with the link read
                    ram_re     = 1'b1;
                    state_next = S_POP;
                    res_valid  = 1'b0;
                end
                else if (eida_pkg::CMP_W'(bump_reg) >= eida_pkg::CMP_W'(eida_pkg::CAPACITY))
                begin
                    res.status = eida_pkg::ST_NOMEM;
                end
                else
                begin
                    res.id    = eida_pkg::ID_W'(bump_reg);
                    res.live  = live_inc;
                    live_next = live_inc;
                    bump_next = bump_reg + 1'b1;
                    // first id of a new chunk extends the freeable range
                    if (bump_reg == reached_reg)
                    begin
                        reached_next = reached_reg +
                                       eida_pkg::BUMP_W'(eida_pkg::CHUNK_ENTRIES);
                    end
                end
            end
            else
            begin
                if (eida_pkg::CMP_W'(free_id) < eida_pkg::CMP_W'(reached_reg))
                begin
                    ram_we        = 1'b1;
                    head_next     = free_id;
                    nonempty_next = 1'b1;
                    live_next     = live_dec;
                    res.live      = live_dec;
                end
                else
                begin
                    res.status = eida_pkg::ST_INVALID;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            limit_reg      <= '0;
            head_reg       <= '0;
            nonempty_reg   <= 1'b0;
            bump_reg       <= '0;
            reached_reg    <= '0;
            live_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            bump_reg     <= bump_next;
            reached_reg  <= reached_next;
            live_reg     <= live_next;
            if (entry_limit_we)
            begin
                limit_reg <= entry_limit;
            end

            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (res_valid)
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign granted_id = out_reg.id;
    assign live_count = out_reg.live;

    `EIDA_ASSERT_NEXT(a_pop_one_cycle, clk, rst_n, state_reg == S_POP, state_reg == S_IDLE)
    `EIDA_ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `EIDA_ASSERT_IMPLIES(a_empty_only_by_pop, clk, rst_n, $fell(nonempty_reg), $past(state_reg == S_POP))
    `EIDA_ASSERT_ALWAYS(a_bump_in_range, clk, rst_n, bump_reg <= reached_reg)

endmodule
